FILE: rtl/dpfs_pkg.sv
// ----------------------------------------------------------------------------
// dpfs_pkg
// Shared types and constants for the depth pixel fusion store.
// ----------------------------------------------------------------------------
package dpfs_pkg;

  // Number of pixels in the store; a power of two.
  localparam int unsigned PIXELS = 65536;
  localparam int unsigned PIX_AW = $clog2(PIXELS);

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // One stored pixel.
  typedef struct packed {
    logic [DATA_W-1:0] rng;
    logic [DATA_W-1:0] sig;
    logic [DATA_W-1:0] grd;
    logic [DATA_W-1:0] cnt;
  } cell_t;

  // Operation codes carried by the kind field.
  localparam logic [1:0] KIND_FUSE    = 2'd0;
  localparam logic [1:0] KIND_REPLACE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CONF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_TOL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REL_TOL  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [DATA_W-1:0] MAX_CONF_RST = 16'd20;
  localparam logic [DATA_W-1:0] ABS_TOL_RST  = 16'd256;
  localparam logic [DATA_W-1:0] REL_TOL_RST  = 16'd6554;

endpackage

FILE: rtl/dpfs_divider.sv
// ----------------------------------------------------------------------------
// dpfs_divider
// Restoring radix-2 divider, one quotient bit per cycle. The caller
// guarantees that the quotient fits in DATA_W bits, so the upper half of
// the dividend is already below the divisor and only DATA_W steps are run.
// ----------------------------------------------------------------------------
module dpfs_divider
  import dpfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2*DATA_W-1:0] dividend,
  input  logic [DATA_W:0]     divisor,
  output logic                done,
  output logic [DATA_W-1:0]   quotient
);

  localparam int unsigned STEP_W = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DATA_W:0]   rem_r;
  logic [DATA_W-1:0] lo_r;
  logic [DATA_W:0]   dsr_r;

  logic [DATA_W+1:0] trial;
  logic [DATA_W+1:0] diff;
  logic              qbit;

  always_comb begin
    trial = {rem_r, lo_r[DATA_W-1]};
    diff  = trial - {1'b0, dsr_r};
    qbit  = (trial >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the low word shifts out dividend bits and shifts in quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend[2*DATA_W-1:DATA_W]};
      lo_r  <= dividend[DATA_W-1:0];
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[DATA_W:0] : trial[DATA_W:0];
      lo_r  <= {lo_r[DATA_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = lo_r;

endmodule

FILE: rtl/depth_pixel_fusion_store_core.sv
// ----------------------------------------------------------------------------
// depth_pixel_fusion_store_core
// Store of depth-panorama pixels with confidence-weighted fusion,
// depth-buffer replace and read, built around one multiplier and one
// shared iterative divider under a small sequencer.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  kind, pixel, range, signal, grad, conf
//   out_     output     out_valid/out_stall accepted, range, signal, grad, conf
//   cfg_     input      cfg_we             cfg_index, cfg_data
//
// After reset a clearing pass writes zero to every pixel, one per cycle;
// no beat is taken meanwhile. Read, replace, rejected fuse and fuse of
// an empty pixel pass only through the read, evaluate and write states;
// an accepted fuse of a filled pixel also makes three 16-step passes
// through the shared divider. One beat is in work at a time. A finished
// result waits in the output register while the next beat is taken; the
// store write holds only if that register is still full.
// ----------------------------------------------------------------------------
module depth_pixel_fusion_store_core
  import dpfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [DATA_W-1:0]    in_pixel,
  input  logic [DATA_W-1:0]    in_range_code,
  input  logic [DATA_W-1:0]    in_signal_in,
  input  logic [DATA_W-1:0]    in_grad_in,
  input  logic [DATA_W-1:0]    in_conf_in,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_accepted,
  output logic [DATA_W-1:0]    out_range_out,
  output logic [DATA_W-1:0]    out_signal_out,
  output logic [DATA_W-1:0]    out_grad_out,
  output logic [DATA_W-1:0]    out_conf_out,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_WR
  } state_t;

  localparam logic [1:0] FLD_RNG = 2'd0;
  localparam logic [1:0] FLD_SIG = 2'd1;
  localparam logic [1:0] FLD_GRD = 2'd2;

  state_t               state_r;
  logic [PIX_AW-1:0]    clr_addr_r;
  logic [DATA_W-1:0]    max_conf_r;
  logic [DATA_W-1:0]    abs_tol_r;
  logic [DATA_W-1:0]    rel_tol_r;

  // Beat held for the duration of the work.
  logic [1:0]           kind_r;
  logic [PIX_AW-1:0]    idx_r;
  logic [DATA_W-1:0]    rc_r;
  logic [DATA_W-1:0]    sg_r;
  logic [DATA_W-1:0]    gr_r;
  logic [DATA_W-1:0]    cf_r;

  cell_t                mem [PIXELS];
  cell_t                cur_r;
  cell_t                res_r;
  logic                 ok_r;
  logic [DATA_W-1:0]    diff_r;
  logic [2*DATA_W-1:0]  prod_r;
  logic [1:0]           fld_r;

  logic                 out_valid_r;
  logic                 out_ok_r;
  cell_t                out_cell_r;

  logic                 in_take;
  logic                 wr_go;
  logic                 mem_we;
  logic [PIX_AW-1:0]    mem_waddr;
  cell_t                mem_wdata;

  logic [DATA_W-1:0]    mul_a;
  logic [DATA_W-1:0]    mul_b;
  logic [2*DATA_W-1:0]  mul_p;
  logic [DATA_W-1:0]    old_fld;
  logic [DATA_W-1:0]    new_fld;

  logic                 div_start;
  logic [2*DATA_W-1:0]  div_dividend;
  logic [DATA_W:0]      div_divisor;
  logic                 div_done;
  logic [DATA_W-1:0]    div_quot;

  logic                 bad;
  logic [DATA_W:0]      conf_inc;
  logic [DATA_W-1:0]    conf_capped;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && (state_r == S_IDLE);
  assign wr_go    = (state_r == S_WR) && (!out_valid_r || !out_stall);

  // Field selection for the blending passes.
  always_comb begin
    case (fld_r)
      FLD_RNG: begin
        old_fld = cur_r.rng;
        new_fld = rc_r;
      end
      FLD_SIG: begin
        old_fld = cur_r.sig;
        new_fld = sg_r;
      end
      default: begin
        old_fld = cur_r.grd;
        new_fld = gr_r;
      end
    endcase
  end

  // The one multiplier: relative tolerance bound first, then old * confidence.
  always_comb begin
    if (state_r == S_RD) begin
      mul_a = rel_tol_r;
      mul_b = cur_r.rng;
    end else begin
      mul_a = old_fld;
      mul_b = cur_r.cnt;
    end
    mul_p = mul_a * mul_b;
  end

  assign div_start    = (state_r == S_LOAD);
  assign div_dividend = prod_r + {{DATA_W{1'b0}}, new_fld};
  assign div_divisor  = {1'b0, cur_r.cnt} + {{DATA_W{1'b0}}, 1'b1};

  dpfs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    bad = (diff_r > abs_tol_r) || ({diff_r, {DATA_W{1'b0}}} > prod_r);
    conf_inc = {1'b0, cur_r.cnt} + {{DATA_W{1'b0}}, 1'b1};
    conf_capped = (conf_inc > {1'b0, max_conf_r}) ? max_conf_r : conf_inc[DATA_W-1:0];
  end

  // Store write port: zeroing sweep after reset, otherwise the finished pixel.
  always_comb begin
    mem_we    = (state_r == S_CLEAR) || wr_go;
    mem_waddr = (state_r == S_CLEAR) ? clr_addr_r : idx_r;
    mem_wdata = (state_r == S_CLEAR) ? '0 : res_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_take) begin
      cur_r <= mem[PIX_AW'(in_pixel)];
    end
  end

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      max_conf_r  <= MAX_CONF_RST;
      abs_tol_r   <= ABS_TOL_RST;
      rel_tol_r   <= REL_TOL_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_CONF: max_conf_r <= cfg_data;
          REG_ABS_TOL:  abs_tol_r  <= cfg_data;
          REG_REL_TOL:  rel_tol_r  <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (&clr_addr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            kind_r  <= in_kind;
            idx_r   <= PIX_AW'(in_pixel);
            rc_r    <= in_range_code;
            sg_r    <= in_signal_in;
            gr_r    <= in_grad_in;
            cf_r    <= in_conf_in;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          diff_r  <= (rc_r > cur_r.rng) ? rc_r - cur_r.rng : cur_r.rng - rc_r;
          prod_r  <= mul_p;
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          res_r   <= cur_r;
          ok_r    <= 1'b0;
          state_r <= S_WR;
          case (kind_r)
            KIND_FUSE: begin
              if (cur_r.rng == '0) begin
                res_r.rng <= rc_r;
                res_r.sig <= sg_r;
                res_r.cnt <= max_conf_r >> 1;
                ok_r      <= 1'b1;
              end else if (bad) begin
                if (cur_r.cnt != '0) begin
                  res_r.cnt <= cur_r.cnt - 1'b1;
                end
              end else begin
                res_r.cnt <= conf_capped;
                ok_r      <= 1'b1;
                fld_r     <= FLD_RNG;
                state_r   <= S_MUL;
              end
            end
            KIND_REPLACE: begin
              if ((cur_r.rng == '0) || (rc_r < cur_r.rng)) begin
                res_r.rng <= rc_r;
                res_r.sig <= sg_r;
                res_r.cnt <= cf_r >> 1;
                ok_r      <= 1'b1;
              end
            end
            KIND_READ: begin
              ok_r <= 1'b1;
            end
            default: ;
          endcase
        end
        S_MUL: begin
          prod_r  <= mul_p;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            case (fld_r)
              FLD_RNG: res_r.rng <= div_quot;
              FLD_SIG: res_r.sig <= div_quot;
              default: res_r.grd <= div_quot;
            endcase
            if (fld_r == FLD_GRD) begin
              state_r <= S_WR;
            end else begin
              fld_r   <= fld_r + 1'b1;
              state_r <= S_MUL;
            end
          end
        end
        S_WR: begin
          if (wr_go) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= ok_r;
            out_cell_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_ok_r;
  assign out_range_out  = out_cell_r.rng;
  assign out_signal_out = out_cell_r.sig;
  assign out_grad_out   = out_cell_r.grd;
  assign out_conf_out   = out_cell_r.cnt;

endmodule
